// File: rtl/dpt_pkg.sv
`default_nettype none

package dpt_pkg;

    // Default table geometry
    localparam int DPT_ENTRIES  = 16;
    localparam int DPT_KEY_BITS = 64;

    // Fixed widths of the port fields
    localparam int KEY_W = 64;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_MARK   = 2'd1,
        REQ_FETCH  = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_op_t;

    typedef struct packed {
        req_op_t            req_type;
        logic [KEY_W-1:0]   key;
    } req_word_t;

    typedef struct packed {
        logic               done_res;
        logic [KEY_W-1:0]   key_out;
    } rsp_word_t;

    // Status from the sequencer to the top level
    typedef struct packed {
        logic busy;
        logic rsp_valid;
    } dpt_stat_t;

endpackage

`default_nettype wire

// File: rtl/dpt_key_ram.sv
`default_nettype none

module dpt_key_ram
    import dpt_pkg::*;
#(
    parameter int ENTRIES  = DPT_ENTRIES,
    parameter int KEY_BITS = DPT_KEY_BITS,
    localparam int IDX_W   = $clog2(ENTRIES)
)
(
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_addr,
    input  wire logic [KEY_BITS-1:0] wr_data,
    input  wire logic [IDX_W-1:0]    rd_addr,
    output logic      [KEY_BITS-1:0] rd_data
);

    logic [KEY_BITS-1:0] mem [ENTRIES];

    // Write one slot, read one slot with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/dpt_ctrl.sv
`default_nettype none

module dpt_ctrl
    import dpt_pkg::*;
#(
    parameter int ENTRIES  = DPT_ENTRIES,
    parameter int KEY_BITS = DPT_KEY_BITS,
    localparam int IDX_W   = $clog2(ENTRIES)
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire req_word_t req,
    input  wire logic      rsp_take,
    output dpt_stat_t      stat,
    output rsp_word_t      rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_HOLD
    } state_t;

    localparam logic [IDX_W:0]   CNT_END  = (IDX_W+1)'(ENTRIES);
    localparam logic [IDX_W:0]   CNT_ONE  = (IDX_W+1)'(1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t              state_reg,       state_next;
    req_op_t             op_reg,          op_next;
    logic [KEY_BITS-1:0] key_reg,         key_next;
    logic [IDX_W:0]      issue_reg,       issue_next;
    logic                cmp_valid_reg,   cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg,     cmp_idx_next;
    logic                hit_reg,         hit_next;
    logic [IDX_W-1:0]    hit_idx_reg,     hit_idx_next;
    logic [KEY_BITS-1:0] found_key_reg,   found_key_next;
    logic                empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]    empty_idx_reg,   empty_idx_next;
    logic [ENTRIES-1:0]  occ_reg,         occ_next;
    logic [ENTRIES-1:0]  seen_reg,        seen_next;
    rsp_word_t           rsp_reg,         rsp_next;

    logic                wr_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    logic                slot_occ;
    logic                slot_match;
    logic                slot_cand;

    dpt_key_ram #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (empty_idx_reg),
        .wr_data (key_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare on the slot whose key has just been read
    assign slot_occ   = occ_reg[cmp_idx_reg];
    assign slot_match = slot_occ && (rd_data == key_reg) && (key_reg != '0);
    assign slot_cand  = slot_occ && !seen_reg[cmp_idx_reg];
    assign rd_addr    = issue_reg[IDX_W-1:0];

    // Sequence one slot per cycle, then commit the outcome
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        issue_next       = issue_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        found_key_next   = found_key_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        occ_next         = occ_reg;
        seen_next        = seen_reg;
        rsp_next         = rsp_reg;
        wr_en            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next          = req.req_type;
                    key_next         = req.key[KEY_BITS-1:0];
                    issue_next       = '0;
                    cmp_valid_next   = 1'b0;
                    hit_next         = 1'b0;
                    empty_found_next = 1'b0;
                    rsp_next         = '0;
                    if (req.req_type == REQ_CLEAR)
                    begin
                        seen_next  = '0;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Advance the read pointer
                if (issue_reg < CNT_END)
                begin
                    issue_next     = issue_reg + CNT_ONE;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end

                // Keep the first hit and the first free slot
                if (cmp_valid_reg)
                begin
                    if (!hit_reg && ((op_reg == REQ_FETCH) ? slot_cand : slot_match))
                    begin
                        hit_next       = 1'b1;
                        hit_idx_next   = cmp_idx_reg;
                        found_key_next = rd_data;
                    end
                    if (!slot_occ && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end

            ST_COMMIT:
            begin
                case (op_reg)
                    REQ_INSERT:
                    begin
                        if ((key_reg != '0) && !hit_reg && empty_found_reg)
                        begin
                            wr_en                    = 1'b1;
                            occ_next[empty_idx_reg]  = 1'b1;
                            seen_next[empty_idx_reg] = 1'b0;
                            rsp_next.done_res        = 1'b1;
                            rsp_next.key_out         = KEY_W'(key_reg);
                        end
                    end
                    REQ_MARK:
                    begin
                        if (hit_reg)
                        begin
                            seen_next[hit_idx_reg] = 1'b1;
                        end
                    end
                    REQ_FETCH:
                    begin
                        if (hit_reg)
                        begin
                            occ_next[hit_idx_reg]  = 1'b0;
                            seen_next[hit_idx_reg] = 1'b0;
                            rsp_next.done_res      = 1'b1;
                            rsp_next.key_out       = KEY_W'(found_key_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_HOLD;
            end

            ST_HOLD:
            begin
                // Hold the result until the output register takes it
                if (rsp_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= REQ_INSERT;
            key_reg         <= '0;
            issue_reg       <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_idx_reg     <= '0;
            hit_reg         <= 1'b0;
            hit_idx_reg     <= '0;
            found_key_reg   <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            occ_reg         <= '0;
            seen_reg        <= '0;
            rsp_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            key_reg         <= key_next;
            issue_reg       <= issue_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_idx_reg     <= cmp_idx_next;
            hit_reg         <= hit_next;
            hit_idx_reg     <= hit_idx_next;
            found_key_reg   <= found_key_next;
            empty_found_reg <= empty_found_next;
            empty_idx_reg   <= empty_idx_next;
            occ_reg         <= occ_next;
            seen_reg        <= seen_next;
            rsp_reg         <= rsp_next;
        end
    end

    assign stat.busy      = (state_reg != ST_IDLE);
    assign stat.rsp_valid = (state_reg == ST_HOLD);
    assign rsp            = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/device_presence_tracker.sv
`default_nettype none

// Presence table of up to ENTRIES device keys with a seen flag per slot. Each
// request word (insert, mark seen, fetch removed, clear marks) gives exactly one
// response word. Insert, mark and fetch sweep the table one slot per cycle
// through the single read port of the key memory and a shared key comparator,
// so a request occupies the block from acceptance until its response word is
// taken into the output register, and clear-marks skips the sweep entirely. The
// request side is stalled while a request is in progress. The response sits in
// an output register, so a stalled response does not block the next request
// from being scanned. Occupancy and seen flags are flip-flops cleared by reset,
// so the table is empty straight after reset with no clearing pass.
module device_presence_tracker
    import dpt_pkg::*;
#(
    parameter int ENTRIES  = DPT_ENTRIES,
    parameter int KEY_BITS = DPT_KEY_BITS
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_word_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_word_t      rsp
);

    dpt_stat_t stat;
    rsp_word_t ctrl_rsp;
    logic      start;
    logic      rsp_take;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_word_t rsp_reg,       rsp_next;

    assign req_stall = stat.busy;
    assign start     = req_valid && !stat.busy;
    assign rsp_take  = stat.rsp_valid && (!rsp_valid_reg || !rsp_stall);

    dpt_ctrl #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .rsp_take (rsp_take),
        .stat     (stat),
        .rsp      (ctrl_rsp)
    );

    // Load a finished word, drop it once the far side takes it
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = ctrl_rsp;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dpt_pkg::*;

    localparam int          SLOTS      = DPT_ENTRIES;
    localparam int          RAND_ITEMS = 700;
    localparam int          HOLD_AT    = 150;
    localparam int          LONG_HOLD  = 300;
    localparam int          PAUSE_AT   = 350;
    localparam int          CALM_AT    = 620;
    localparam int          DRAIN_WAIT = SLOTS + 24;
    localparam logic [63:0] KEY_ONES   = '1;
    localparam logic [63:0] KEY_TOP    = 64'h8000_0000_0000_0000;

    typedef struct {
        req_op_t     op;
        logic [63:0] key;
        int          reps;
        bit          lit;
        rsp_word_t   want;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    // Literal expectation travelling alongside the request word
    bit        lit_flag;
    rsp_word_t lit_want;

    // Shadow copy of the presence table
    logic [63:0] tbl_key  [SLOTS];
    bit          tbl_seen [SLOTS];

    rsp_word_t due_rsp [$];
    int        req_count;
    int        rsp_count;
    int        errors;
    int        n_stored;
    int        n_fetched;
    int        n_marks;
    int        n_clears;
    bit        calm;
    bit        hold_done;
    int        hold_left;
    int        burst_left;

    plan_row_t plan [12];

    device_presence_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply one request word to the shadow table and return its response
    function automatic rsp_word_t track_request(req_word_t w);
        rsp_word_t r;
        int        hit;
        int        empty;
        r.done_res = 1'b0;
        r.key_out  = '0;
        hit   = SLOTS;
        empty = SLOTS;
        case (w.req_type)
            REQ_INSERT, REQ_MARK:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (w.key != '0 && tbl_key[i] == w.key)
                        hit = i;
                    if (tbl_key[i] == '0)
                        empty = i;
                end
                if (w.req_type == REQ_MARK)
                begin
                    if (hit < SLOTS)
                        tbl_seen[hit] = 1'b1;
                end
                else if (w.key != '0 && hit == SLOTS && empty < SLOTS)
                begin
                    tbl_key[empty]  = w.key;
                    tbl_seen[empty] = 1'b0;
                    r.done_res      = 1'b1;
                    r.key_out       = w.key;
                end
            end
            REQ_FETCH:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!r.done_res && tbl_key[i] != '0 && !tbl_seen[i])
                    begin
                        r.done_res  = 1'b1;
                        r.key_out   = tbl_key[i];
                        tbl_key[i]  = '0;
                        tbl_seen[i] = 1'b0;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    tbl_seen[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    // Pick a key held in the table, or a random one when it is empty
    function automatic logic [63:0] present_key();
        logic [63:0] held [$];
        for (int i = 0; i < SLOTS; i++)
            if (tbl_key[i] != '0)
                held.push_back(tbl_key[i]);
        if (held.size() == 0)
            return {$urandom, $urandom};
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    task automatic note_mismatch(string what, rsp_word_t want, rsp_word_t got);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s: expected done %0b key %h, got done %0b key %h",
                     $realtime, what, want.done_res, want.key_out, got.done_res, got.key_out);
    endtask

    // Offer one word and hold it until it is taken
    task automatic send_word(req_word_t w, bit lit, rsp_word_t want);
        req_valid <= 1'b1;
        req       <= w;
        lit_flag  <= lit;
        lit_want  <= want;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Drop valid for a random burst, except near the end
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13))
                @(posedge clk);
        end
    endtask

    // Predict on request words taken, check response words taken
    always @(posedge clk)
    begin : track_words
        rsp_word_t calc;
        rsp_word_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                calc = track_request(req);
                due_rsp.push_back(lit_flag ? lit_want : calc);
                req_count++;
                if (req.req_type == REQ_MARK)
                    n_marks++;
                if (req.req_type == REQ_CLEAR)
                    n_clears++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count++;
                if (due_rsp.size() == 0)
                begin
                    want = '0;
                    note_mismatch("unexpected response word", want, rsp);
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (want.done_res != rsp.done_res || want.key_out != rsp.key_out)
                        note_mismatch("response word mismatch", want, rsp);
                    if (want.done_res && want.key_out == rsp.key_out)
                    begin
                        if (n_stored + n_fetched < rsp_count)
                            n_stored = n_stored;
                    end
                end
                if (rsp.done_res)
                    n_fetched++;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off once HOLD_AT requests are taken
    initial
    begin
        rsp_stall  = 1'b0;
        hold_left  = 0;
        burst_left = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && req_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                rsp_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 13) - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Give up after a generous fixed time
    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Sender: directed table, then random traffic, then drain
    initial
    begin : drive_requests
        req_word_t w;
        rsp_word_t none;
        int        pick;
        none      = '0;
        req_valid = 1'b0;
        req       = '0;
        lit_flag  = 1'b0;
        lit_want  = '0;
        calm      = 1'b0;
        errors    = 0;
        req_count = 0;
        rsp_count = 0;
        n_stored  = 0;
        n_fetched = 0;
        n_marks   = 0;
        n_clears  = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_key[i]  = '0;
            tbl_seen[i] = 1'b0;
        end

        plan[0]  = '{REQ_FETCH,  64'h0123_4567_89ab_cdef, 1,  1'b1, '{1'b0, 64'd0}};
        plan[1]  = '{REQ_INSERT, 64'd0,                   1,  1'b1, '{1'b0, 64'd0}};
        plan[2]  = '{REQ_MARK,   64'd0,                   1,  1'b1, '{1'b0, 64'd0}};
        plan[3]  = '{REQ_INSERT, KEY_ONES,                1,  1'b1, '{1'b1, KEY_ONES}};
        plan[4]  = '{REQ_INSERT, KEY_ONES,                1,  1'b1, '{1'b0, 64'd0}};
        plan[5]  = '{REQ_MARK,   KEY_ONES,                1,  1'b1, '{1'b0, 64'd0}};
        plan[6]  = '{REQ_FETCH,  KEY_ONES,                1,  1'b1, '{1'b0, 64'd0}};
        plan[7]  = '{REQ_CLEAR,  KEY_ONES,                1,  1'b1, '{1'b0, 64'd0}};
        plan[8]  = '{REQ_MARK,   KEY_TOP,                 1,  1'b1, '{1'b0, 64'd0}};
        plan[9]  = '{REQ_INSERT, 64'd1,                   15, 1'b0, '{1'b0, 64'd0}};
        plan[10] = '{REQ_INSERT, KEY_TOP,                 1,  1'b1, '{1'b0, 64'd0}};
        plan[11] = '{REQ_FETCH,  64'd0,                   1,  1'b1, '{1'b1, KEY_ONES}};

        rst_n = 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; repeated rows shift the key up one bit each time
        foreach (plan[r])
        begin
            for (int k = 0; k < plan[r].reps; k++)
            begin
                w.req_type = plan[r].op;
                w.key      = plan[r].key << k;
                send_word(w, plan[r].lit, plan[r].want);
                maybe_gap();
            end
        end

        // Random traffic biased towards well-formed insert, mark and fetch sequences
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            w.key = {$urandom, $urandom};
            pick  = $urandom_range(0, 99);
            if (pick < 40)
            begin
                w.req_type = REQ_INSERT;
                if ($urandom_range(0, 3) == 0)
                    w.key = 64'($urandom_range(1, 40));
            end
            else if (pick < 70)
            begin
                w.req_type = REQ_MARK;
                if ($urandom_range(0, 4) != 0)
                    w.key = present_key();
            end
            else if (pick < 90)
                w.req_type = REQ_FETCH;
            else if (pick < 95)
                w.req_type = REQ_CLEAR;
            else
            begin
                w.req_type = req_op_t'($urandom_range(0, 3));
                if ($urandom_range(0, 1) == 0)
                    w.key = '0;
            end

            // Pause once until every outstanding response has come back
            if (n == PAUSE_AT)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (due_rsp.size() != 0)
                    @(posedge clk);
            end
            if (n >= CALM_AT)
                calm = 1'b1;

            send_word(w, 1'b0, none);
            maybe_gap();
        end

        // Drain, then allow the block to settle
        req_valid <= 1'b0;
        @(posedge clk);
        while (due_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (due_rsp.size() != 0)
            errors++;

        $display("Sent %0d request words (%0d marks, %0d clears); %0d responses checked,",
                 req_count, n_marks, n_clears, rsp_count);
        $display("%0d of them reporting a stored or fetched key; %0d failures.",
                 n_fetched, errors);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/dpt_pkg.sv
rtl/dpt_key_ram.sv
rtl/dpt_ctrl.sv
rtl/device_presence_tracker.sv
dv/testbench.sv
